/* src/fccbs_pkg.sv */
// Shared types, constants, lattice helpers and the microcode ROM of the bond rate-class unit.
package fccbs_pkg;

  localparam int X_BITS  = 5;
  localparam int Y_BITS  = 5;
  localparam int Z_BITS  = 5;
  localparam int ZH_BITS = Z_BITS - 1;

  localparam int KEY_W       = 17;
  localparam int SITE_IN_W   = 14;
  localparam int QUOT_W      = 15;
  localparam int ADDR_W      = 14;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CLASS_W     = 4;
  localparam int CNT_W       = 5;
  localparam int ACC_W       = 5;
  localparam int NBR_W       = 4;
  localparam int DIR_W       = 3;

  // floor(key / 6) == (key * 43691) >> 18 for every 17-bit key
  localparam int               RECIP_SHIFT = 18;
  localparam logic [KEY_W-1:0] RECIP6      = 17'd43691;
  localparam logic [KEY_W-1:0] BOND_DIRS   = 17'd6;
  localparam logic [NBR_W-1:0] NBR_LAST    = 4'd11;
  localparam logic [CNT_W-1:0] CNT_RESET   = 5'd12;
  localparam logic signed [ACC_W-1:0] ACC_MAX = 5'sd12;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -5'sd12;
  localparam logic [CLASS_W-1:0] CLASS_MAX = 4'd12;

  typedef struct packed {
    logic [X_BITS-1:0] x;
    logic [Y_BITS-1:0] y;
    logic [Z_BITS-1:0] z;
  } coord_t;

  typedef enum logic [1:0] {RD_NONE, RD_A, RD_B, RD_NBR} rd_e;
  typedef enum logic [1:0] {EM_NONE, EM_CLASS, EM_INACT} emit_e;
  typedef enum logic [1:0] {BR_NEXT, BR_START, BR_SAME, BR_LOOP} br_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC_Q, S_DEC_C, S_RD_A, S_RD_B, S_CHECK, S_SCAN, S_DRAIN, S_EMIT, S_EMIT_INACT
  } step_e;

  typedef struct packed {
    logic  ld_key;
    logic  ld_site;
    logic  ld_coord;
    rd_e   rd;
    logic  cap_sa;
    logic  clr_acc;
    emit_e emit;
    br_e   br;
    step_e nxt;
  } uword_t;

  typedef struct packed {
    uword_t           uw;
    logic [NBR_W-1:0] nbr;
    logic             pass;
  } seq_ctrl_t;

  typedef struct packed {
    logic same;
  } dp_status_t;

  function automatic uword_t ucode(step_e s);
    uword_t w;
    w = '0;
    case (s)
      S_IDLE:       begin w.ld_key = 1'b1; w.br = BR_START; w.nxt = S_DEC_Q; end
      S_DEC_Q:      begin w.ld_site = 1'b1; w.nxt = S_DEC_C; end
      S_DEC_C:      begin w.ld_coord = 1'b1; w.nxt = S_RD_A; end
      S_RD_A:       begin w.rd = RD_A; w.nxt = S_RD_B; end
      S_RD_B:       begin w.rd = RD_B; w.cap_sa = 1'b1; w.nxt = S_CHECK; end
      S_CHECK:      begin w.clr_acc = 1'b1; w.br = BR_SAME; w.nxt = S_EMIT_INACT; end
      S_SCAN:       begin w.rd = RD_NBR; w.br = BR_LOOP; w.nxt = S_DRAIN; end
      S_DRAIN:      begin w.nxt = S_EMIT; end
      S_EMIT:       begin w.emit = EM_CLASS; w.nxt = S_IDLE; end
      S_EMIT_INACT: begin w.emit = EM_INACT; w.nxt = S_IDLE; end
      default:      begin w.nxt = S_IDLE; end
    endcase
    return w;
  endfunction

  // split a site number into coordinates; the low z bit follows from x ^ y
  function automatic coord_t coord_of(logic [QUOT_W-1:0] site);
    coord_t     c;
    logic [31:0] s;
    s   = 32'(site);
    c.y = Y_BITS'(s >> ZH_BITS);
    c.x = X_BITS'(s >> (ZH_BITS + Y_BITS));
    c.z = Z_BITS'({s, c.x[0] ^ c.y[0]});
    return c;
  endfunction

  function automatic coord_t nbr_of(coord_t c, logic [NBR_W-1:0] d);
    coord_t            n;
    logic [X_BITS-1:0] xp, xm;
    logic [Y_BITS-1:0] yp, ym;
    logic [Z_BITS-1:0] zp, zm;
    xp = c.x + X_BITS'(1);
    xm = c.x - X_BITS'(1);
    yp = c.y + Y_BITS'(1);
    ym = c.y - Y_BITS'(1);
    zp = c.z + Z_BITS'(1);
    zm = c.z - Z_BITS'(1);
    n  = c;
    case (d)
      4'd0:    begin n.x = xp; n.z = zp; end
      4'd1:    begin n.y = ym; n.z = zp; end
      4'd2:    begin n.x = xm; n.z = zp; end
      4'd3:    begin n.y = yp; n.z = zp; end
      4'd4:    begin n.x = xp; n.y = yp; end
      4'd5:    begin n.x = xm; n.y = yp; end
      4'd6:    begin n.y = yp; n.z = zm; end
      4'd7:    begin n.x = xp; n.z = zm; end
      4'd8:    begin n.x = xm; n.z = zm; end
      4'd9:    begin n.y = ym; n.z = zm; end
      4'd10:   begin n.x = xp; n.y = ym; end
      4'd11:   begin n.x = xm; n.y = ym; end
      default: begin n = c; end
    endcase
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(coord_t c);
    logic [31:0] s;
    s = (32'(c.x) << Y_BITS) | 32'(c.y);
    s = (s << ZH_BITS) | 32'(c.z >> 1);
    return s[ADDR_W-1:0];
  endfunction

endpackage

/* src/fccbs_store.sv */
// Single-port species memory, one bit per site, registered read data.
module fccbs_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [fccbs_pkg::ADDR_W-1:0] addr_i,
  input  logic                         wdata_i,
  output logic                         rdata_o
);
  import fccbs_pkg::*;

  logic mem_q [STORE_DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/fccbs_seq.sv */
// Microcode sequencer: step counter, ROM lookup, neighbour loop counter and branches.
module fccbs_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  kind_i,
  input  fccbs_pkg::dp_status_t status_i,
  output fccbs_pkg::seq_ctrl_t  ctl_o,
  output logic                  busy_o
);
  import fccbs_pkg::*;

  step_e            upc_q, upc_d;
  logic [NBR_W-1:0] nbr_q, nbr_d;
  logic             pass_q, pass_d;
  uword_t           uw;

  assign uw = ucode(upc_q);

  always_comb begin
    upc_d  = upc_q;
    nbr_d  = nbr_q;
    pass_d = pass_q;
    case (uw.br)
      BR_NEXT:  upc_d = uw.nxt;
      BR_START: if (start_i && kind_i) upc_d = uw.nxt;
      BR_SAME:  upc_d = status_i.same ? uw.nxt : step_e'(upc_q + 4'd1);
      BR_LOOP:  if (nbr_q == NBR_LAST && pass_q) upc_d = uw.nxt;
      default:  upc_d = S_IDLE;
    endcase
    if (uw.clr_acc) begin
      nbr_d  = '0;
      pass_d = 1'b0;
    end else if (uw.rd == RD_NBR) begin
      // wrap after the twelfth neighbour and move on to the other bond end
      nbr_d  = (nbr_q == NBR_LAST) ? '0 : nbr_q + NBR_W'(1);
      pass_d = pass_q | (nbr_q == NBR_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= S_IDLE;
      nbr_q  <= '0;
      pass_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      nbr_q  <= nbr_d;
      pass_q <= pass_d;
    end
  end

  assign ctl_o.uw   = uw;
  assign ctl_o.nbr  = nbr_q;
  assign ctl_o.pass = pass_q;
  assign busy_o     = (upc_q != S_IDLE);

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_IDLE && !(start_i && kind_i)) |=> upc_q == S_IDLE)
    else $error("sequencer left idle without a query");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && kind_i))
    else $error("busy rose without an accepted query");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_DRAIN) |-> (nbr_q == '0 && pass_q))
    else $error("scan ended before both ends were covered");

endmodule

/* src/fccbs_dpath.sv */
// Datapath: key split, coordinates, store addressing, neighbour count and result registers.
module fccbs_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fccbs_pkg::seq_ctrl_t          ctl_i,
  input  logic [fccbs_pkg::KEY_W-1:0]   bond_key_i,
  input  logic [fccbs_pkg::CNT_W-1:0]   class_cnt_i,
  input  logic                          rd_data_i,
  output logic [fccbs_pkg::ADDR_W-1:0]  rd_addr_o,
  output fccbs_pkg::dp_status_t         status_o,
  output logic                          done_o,
  output logic [fccbs_pkg::CLASS_W-1:0] rate_class_o,
  output logic                          inactive_o,
  output logic                          class_error_o
);
  import fccbs_pkg::*;

  logic [KEY_W-1:0]        key_q;
  logic [QUOT_W-1:0]       site_q;
  logic [2*KEY_W-1:0]      prod;
  logic [DIR_W-1:0]        dir;
  coord_t                  a_q, b_q, a_d, center, partner, ncoord;
  logic                    sa_q;
  logic                    use_b;
  logic                    pend_q, skip_q, neg_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [CLASS_W-1:0]      rc;
  logic                    done_q, inact_q, err_q;
  logic [CLASS_W-1:0]      rc_q;

  assign prod = (2*KEY_W)'(key_q) * (2*KEY_W)'(RECIP6);
  assign dir  = DIR_W'(key_q - KEY_W'(site_q) * BOND_DIRS);
  assign a_d  = coord_of(site_q);

  // pass 0 scans the species-0 end, pass 1 the species-1 end
  assign use_b   = sa_q ^ ctl_i.pass;
  assign center  = use_b ? b_q : a_q;
  assign partner = use_b ? a_q : b_q;
  assign ncoord  = nbr_of(center, ctl_i.nbr);

  always_comb begin
    case (ctl_i.uw.rd)
      RD_A:    rd_addr_o = addr_of(a_q);
      RD_B:    rd_addr_o = addr_of(b_q);
      RD_NBR:  rd_addr_o = addr_of(ncoord);
      default: rd_addr_o = addr_of(a_q);
    endcase
  end

  assign status_o.same = (sa_q == rd_data_i);

  assign rc = (acc_q > 0) ? CLASS_W'(acc_q) : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.uw.ld_key) key_q <= bond_key_i;
    if (ctl_i.uw.ld_site) site_q <= QUOT_W'(prod >> RECIP_SHIFT);
    if (ctl_i.uw.ld_coord) begin
      a_q <= a_d;
      b_q <= nbr_of(a_d, NBR_W'(dir));
    end
    if (ctl_i.uw.cap_sa) sa_q <= rd_data_i;
    skip_q <= (ncoord == partner);
    neg_q  <= ctl_i.pass;
    rc_q   <= (ctl_i.uw.emit == EM_CLASS) ? rc : '0;
    inact_q <= (ctl_i.uw.emit == EM_INACT);
    err_q  <= (ctl_i.uw.emit == EM_CLASS) && ({1'b0, rc} >= class_cnt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      pend_q <= (ctl_i.uw.rd == RD_NBR);
      done_q <= (ctl_i.uw.emit != EM_NONE);
      if (ctl_i.uw.clr_acc) begin
        acc_q <= '0;
      end else if (pend_q && !skip_q && !rd_data_i) begin
        // species-0 neighbour: add for the initial end, subtract for the final end
        acc_q <= neg_q ? acc_q - ACC_W'(1) : acc_q + ACC_W'(1);
      end
    end
  end

  assign done_o        = done_q;
  assign rate_class_o  = rc_q;
  assign inactive_o    = inact_q;
  assign class_error_o = err_q;

  a_inactive_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && inact_q) |-> (rc_q == '0 && !err_q))
    else $error("inactive transaction carries a class or error");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q <= ACC_MAX && acc_q >= ACC_MIN))
    else $error("neighbour count difference out of range");

  a_class_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rc_q <= CLASS_MAX)
    else $error("rate class above neighbour count");

endmodule

/* src/fcc_bond_swap_rate_class_unit.sv */
// Top level of the FCC bond rate-class unit: configuration register and wiring.
//
// Usage: drive start high with kind_i and the payload. A transaction is taken at
// a rising edge where start is high and busy is low.
// A write transaction (kind_i = 0) stores species_value_i at site_index_i in that
// same edge; busy stays low and no result follows.
// A query transaction (kind_i = 1) splits bond_key_i into site and direction,
// reads both bond ends, and if their species differ reads the twelve
// neighbors of each end from the single-port species memory, one read a
// cycle. busy stays high through all the neighbor reads of a query with
// differing species and falls sooner when the ends match; the result
// appears on done_o for exactly one cycle after busy falls.
// The result must be taken in the cycle done_o is high; there is no stall.
// Reset clears the sequencer and the strobe and sets the class count to 12;
// the species memory is not cleared and must be written before queries.
// cfg_we_i writes cfg_wdata_i into the class count; write it only while idle.
module fcc_bond_swap_rate_class_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind_i,
  input  logic [fccbs_pkg::SITE_IN_W-1:0]  site_index_i,
  input  logic                             species_value_i,
  input  logic [fccbs_pkg::KEY_W-1:0]      bond_key_i,
  input  logic                             cfg_we_i,
  input  logic [fccbs_pkg::CNT_W-1:0]      cfg_wdata_i,
  output logic                             done_o,
  output logic [fccbs_pkg::CLASS_W-1:0]    rate_class_o,
  output logic                             inactive_o,
  output logic                             class_error_o
);
  import fccbs_pkg::*;

  logic [CNT_W-1:0]  cnt_q;
  seq_ctrl_t         ctl;
  dp_status_t        status;
  logic              busy_w;
  logic              we;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] addr;
  logic              rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  assign we   = start && !busy_w && !kind_i;
  assign addr = we ? ADDR_W'(site_index_i) : rd_addr;
  assign busy = busy_w;

  fccbs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (kind_i),
    .status_i (status),
    .ctl_o    (ctl),
    .busy_o   (busy_w)
  );

  fccbs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .bond_key_i    (bond_key_i),
    .class_cnt_i   (cnt_q),
    .rd_data_i     (rd_data),
    .rd_addr_o     (rd_addr),
    .status_o      (status),
    .done_o        (done_o),
    .rate_class_o  (rate_class_o),
    .inactive_o    (inactive_o),
    .class_error_o (class_error_o)
  );

  fccbs_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (species_value_i),
    .rdata_o (rd_data)
  );

endmodule

/* dv/fcc_bond_swap_rate_class_unit_tb.sv */
// Self-checking testbench for the FCC bond rate-class unit with a scoreboard-based predictor.
module fcc_bond_swap_rate_class_unit_tb;
  import fccbs_pkg::*;

  localparam logic KIND_WRITE    = 1'b0;
  localparam logic KIND_QUERY    = 1'b1;
  localparam int   NBR_COUNT     = int'(NBR_LAST) + 1;
  localparam int   KEY_TOP       = 98303;
  localparam int   KEY_ALL       = (1 << KEY_W) - 1;
  localparam int   QUERY_CYCLES  = 32;
  localparam int   PHASES        = 8;
  localparam int   PHASE_ITEMS   = 205;

  typedef struct packed {
    logic [CLASS_W-1:0] rate_class;
    logic               inactive;
    logic               class_error;
  } bond_verdict_t;

  class rate_class_scoreboard;
    bit               species_mem [STORE_DEPTH];
    bit               site_set [STORE_DEPTH];
    logic [CNT_W-1:0] class_count;
    bond_verdict_t    verdicts_due [$];
    int               fail_count;
    int               query_count;
    int               inactive_count;
    int               flagged_count;
    int               write_count;
    int               top_class;
    int               dx [NBR_COUNT] = '{1, 0, -1, 0, 1, -1, 0, 1, -1, 0, 1, -1};
    int               dy [NBR_COUNT] = '{0, -1, 0, 1, 1, 1, 1, 0, 0, -1, -1, -1};
    int               dz [NBR_COUNT] = '{1, 1, 1, 1, 0, 0, -1, -1, -1, -1, 0, 0};

    function new();
      class_count = CNT_RESET;
      fail_count = 0;
      query_count = 0;
      inactive_count = 0;
      flagged_count = 0;
      write_count = 0;
      top_class = 0;
    endfunction

    // low z bit is implied by the parity of x and y
    function coord_t site_coord(int unsigned site);
      coord_t c;
      c.x = X_BITS'(site >> (ZH_BITS + Y_BITS));
      c.y = Y_BITS'(site >> ZH_BITS);
      c.z = {ZH_BITS'(site), c.x[0] ^ c.y[0]};
      return c;
    endfunction

    // wrap each axis by truncation to its width
    function coord_t step(coord_t c, int d);
      coord_t n;
      n.x = c.x + X_BITS'(dx[d]);
      n.y = c.y + Y_BITS'(dy[d]);
      n.z = c.z + Z_BITS'(dz[d]);
      return n;
    endfunction

    function logic [ADDR_W-1:0] slot(coord_t c);
      return ADDR_W'({c.x, c.y, c.z[Z_BITS-1:1]});
    endfunction

    function void split_key(logic [KEY_W-1:0] key, output coord_t c, output int dir);
      int unsigned k;
      k = key;
      c = site_coord(k / int'(BOND_DIRS));
      dir = k % int'(BOND_DIRS);
    endfunction

    function int zeros_around(coord_t c, coord_t skip);
      int     n;
      coord_t m;
      n = 0;
      for (int d = 0; d < NBR_COUNT; d++) begin
        m = step(c, d);
        if (m != skip && !species_mem[slot(m)]) n++;
      end
      return n;
    endfunction

    function void note_class_count(logic [CNT_W-1:0] v);
      class_count = v;
    endfunction

    function void note_item(logic kind, logic [SITE_IN_W-1:0] site, logic sp,
                            logic [KEY_W-1:0] key);
      coord_t        a;
      coord_t        b;
      int            dir;
      int            nini;
      int            nfin;
      int            rc;
      bond_verdict_t v;
      if (kind == KIND_WRITE) begin
        species_mem[site] = sp;
        site_set[site] = 1'b1;
        write_count++;
        return;
      end
      split_key(key, a, dir);
      b = step(a, dir);
      query_count++;
      v = '0;
      if (species_mem[slot(a)] == species_mem[slot(b)]) begin
        v.inactive = 1'b1;
        inactive_count++;
      end else begin
        if (!species_mem[slot(a)]) begin
          nini = zeros_around(a, b);
          nfin = zeros_around(b, a);
        end else begin
          nini = zeros_around(b, a);
          nfin = zeros_around(a, b);
        end
        rc = (nini > nfin) ? nini - nfin : 0;
        v.rate_class = CLASS_W'(rc);
        v.class_error = (rc >= int'(class_count));
        if (v.class_error) flagged_count++;
        if (rc > top_class) top_class = rc;
      end
      verdicts_due = {verdicts_due, v};
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fail_count++;
    endtask

    task check_result(logic [CLASS_W-1:0] rc, logic inact, logic cerr);
      bond_verdict_t v;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result with no query waiting (class %0d)", rc));
        return;
      end
      v = verdicts_due.pop_front();
      if (rc !== v.rate_class)
        report_mismatch($sformatf("rate_class %0d, want %0d", rc, v.rate_class));
      if (inact !== v.inactive)
        report_mismatch($sformatf("inactive %b, want %b", inact, v.inactive));
      if (cerr !== v.class_error)
        report_mismatch($sformatf("class_error %b, want %b", cerr, v.class_error));
    endtask

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 kind_i;
  logic [SITE_IN_W-1:0] site_index_i;
  logic                 species_value_i;
  logic [KEY_W-1:0]     bond_key_i;
  logic                 cfg_we_i;
  logic [CNT_W-1:0]     cfg_wdata_i;
  logic                 done_o;
  logic [CLASS_W-1:0]   rate_class_o;
  logic                 inactive_o;
  logic                 class_error_o;

  rate_class_scoreboard sb;
  bit                   idle_on;
  int                   sent_items;
  int                   count_settings;

  fcc_bond_swap_rate_class_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .site_index_i    (site_index_i),
    .species_value_i (species_value_i),
    .bond_key_i      (bond_key_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .rate_class_o    (rate_class_o),
    .inactive_o      (inactive_o),
    .class_error_o   (class_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("fcc_bond_swap_rate_class_unit verification failed");
    $finish;
  end

  // check results before noting a transaction taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(rate_class_o, inactive_o, class_error_o);
      if (cfg_we_i) sb.note_class_count(cfg_wdata_i);
      if (start && !busy) sb.note_item(kind_i, site_index_i, species_value_i, bond_key_i);
    end
  end

  task send_item(logic k, logic [SITE_IN_W-1:0] site, logic sp, logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    start = 1'b1;
    kind_i = k;
    site_index_i = site;
    species_value_i = sp;
    bond_key_i = key;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    sent_items++;
  endtask

  task put_site(coord_t c, bit sp);
    send_item(KIND_WRITE, sb.slot(c), sp, KEY_W'($urandom));
  endtask

  // write any site that a query on this bond reads and that was never written
  task fill_bond(logic [KEY_W-1:0] key);
    coord_t a;
    coord_t b;
    coord_t m;
    int     dir;
    sb.split_key(key, a, dir);
    b = sb.step(a, dir);
    if (!sb.site_set[sb.slot(a)]) put_site(a, 1'($urandom));
    if (!sb.site_set[sb.slot(b)]) put_site(b, 1'($urandom));
    for (int d = 0; d < NBR_COUNT; d++) begin
      m = sb.step(a, d);
      if (!sb.site_set[sb.slot(m)]) put_site(m, 1'($urandom));
      m = sb.step(b, d);
      if (!sb.site_set[sb.slot(m)]) put_site(m, 1'($urandom));
    end
  endtask

  task ask_bond(logic [KEY_W-1:0] key);
    fill_bond(key);
    send_item(KIND_QUERY, SITE_IN_W'($urandom), 1'($urandom), key);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 7) == 0) return KEY_W'($urandom_range(KEY_TOP + 1, KEY_ALL));
    return KEY_W'($urandom_range(0, KEY_TOP));
  endfunction

  // hold off until every query has answered and the block is idle
  task settle();
    int guard;
    guard = 0;
    start = 1'b0;
    while ((sb.pending() != 0 || busy) && guard < 4000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (QUERY_CYCLES + 8) @(negedge clk_i);
  endtask

  task set_class_count(logic [CNT_W-1:0] v);
    settle();
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    count_settings++;
  endtask

  // shape the neighborhood of a bond, then query it
  task run_bond(logic [KEY_W-1:0] key);
    coord_t a;
    coord_t b;
    coord_t zero_end;
    coord_t one_end;
    coord_t m;
    int     dir;
    int     bias;
    bit     a_sp;
    bit     b_sp;
    bit     full;
    sb.split_key(key, a, dir);
    b = sb.step(a, dir);
    a_sp = 1'($urandom);
    b_sp = ($urandom_range(0, 5) == 0) ? a_sp : !a_sp;
    zero_end = a_sp ? b : a;
    one_end = a_sp ? a : b;
    bias = $urandom_range(0, 100);
    full = ($urandom_range(0, 7) == 0);
    // paint the species-0 end first; the species-1 end overwrites shared neighbors
    for (int d = 0; d < NBR_COUNT; d++) begin
      m = sb.step(zero_end, d);
      if (m != one_end && (full || $urandom_range(0, 3) == 0))
        put_site(m, $urandom_range(1, 100) > bias);
    end
    for (int d = 0; d < NBR_COUNT; d++) begin
      m = sb.step(one_end, d);
      if (m != zero_end && (full || $urandom_range(0, 3) == 0))
        put_site(m, $urandom_range(1, 100) <= bias);
    end
    put_site(a, a_sp);
    put_site(b, b_sp);
    ask_bond(key);
  endtask

  initial begin
    logic [CNT_W-1:0] phase_count;
    int               pick;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_WRITE;
    site_index_i = '0;
    species_value_i = 1'b0;
    bond_key_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    idle_on = 1'b1;
    sent_items = 0;
    count_settings = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every direction, keys past the lattice
    send_item(KIND_WRITE, '0, 1'b0, KEY_W'(KEY_ALL));
    send_item(KIND_WRITE, SITE_IN_W'(STORE_DEPTH - 1), 1'b1, '0);
    send_item(KIND_WRITE, SITE_IN_W'(STORE_DEPTH / 2 - 1), 1'b1, KEY_W'(KEY_ALL));
    for (int d = 0; d < int'(BOND_DIRS); d++) ask_bond(KEY_W'(d));
    for (int d = 0; d < int'(BOND_DIRS); d++) ask_bond(KEY_W'(KEY_TOP - d));
    fill_bond(KEY_W'(KEY_TOP + 1));
    send_item(KIND_QUERY, SITE_IN_W'(STORE_DEPTH - 1), 1'b1, KEY_W'(KEY_TOP + 1));
    fill_bond(KEY_W'(KEY_ALL));
    send_item(KIND_QUERY, '0, 1'b0, KEY_W'(KEY_ALL));
    ask_bond(KEY_W'(1 << (KEY_W - 1)));
    send_item(KIND_WRITE, '0, 1'b1, '0);
    ask_bond('0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_count = '0;
        1:       phase_count = CNT_W'(1);
        2:       phase_count = '1;
        3:       phase_count = CNT_W'(16);
        6:       phase_count = CNT_RESET;
        default: phase_count = CNT_W'($urandom_range(1, 16));
      endcase
      set_class_count(phase_count);
      idle_on = (p != PHASES - 1);
      sent_items = 0;
      while (sent_items < PHASE_ITEMS) begin
        // leave stretches without idling
        if (p != PHASES - 1 && $urandom_range(0, 29) == 0) idle_on = !idle_on;
        pick = $urandom_range(0, 99);
        if (pick < 55) run_bond(pick_key());
        else if (pick < 75) send_item(KIND_WRITE, SITE_IN_W'($urandom), 1'($urandom),
                                      KEY_W'($urandom));
        else ask_bond(pick_key());
        if ($urandom_range(0, 59) == 0) settle();
      end
    end
    settle();

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d queries never answered", sb.pending()));
    $display("Run covered %0d bond queries (%0d inactive, %0d flagged, top class %0d)",
             sb.query_count, sb.inactive_count, sb.flagged_count, sb.top_class);
    $display("and %0d site writes over %0d class-count settings.", sb.write_count,
             count_settings);
    if (sb.fail_count == 0) begin
      $display("fcc_bond_swap_rate_class_unit verification clean");
    end else begin
      $display("fcc_bond_swap_rate_class_unit verification failed");
    end
    $finish;
  end

endmodule
